// ===== rtl/lstp_pkg.sv =====
// lstp_pkg: shared types, constants and helpers for the least slack time picker
// used by lstp_front, lstp_back and least_slack_time_picker
`timescale 1ns / 1ps
`default_nettype none

package lstp_pkg;

   localparam int TIME_WIDTH = 16;
   localparam int ID_WIDTH   = 8;
   localparam int IDLE_WAIT  = 100;
   localparam int SLACK_W    = TIME_WIDTH + 2;
   localparam int LIMIT_W    = TIME_WIDTH + 1;

   localparam logic signed [SLACK_W-1:0] GAP_NONE = {1'b0, {LIMIT_W{1'b1}}};
   localparam logic signed [SLACK_W-1:0] IDLE_GAP = SLACK_W'(IDLE_WAIT);

   typedef enum logic [1:0] {
      OP_BEGIN   = 2'd0,
      OP_RUN     = 2'd1,
      OP_RELEASE = 2'd2,
      OP_DECIDE  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0]            command;
      logic [TIME_WIDTH-1:0] now;
      logic [ID_WIDTH-1:0]   thread_id;
      logic [TIME_WIDTH-1:0] deadline;
      logic [TIME_WIDTH-1:0] remaining;
      logic [TIME_WIDTH-1:0] release_at;
   } req_type;

   typedef struct packed {
      logic                  selected;
      logic [ID_WIDTH-1:0]   chosen_id;
      logic [TIME_WIDTH-1:0] slice;
      logic                  missed;
      logic                  sequence_error;
   } rsp_type;

   typedef struct packed {
      op_type  op;
      req_type data;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   function automatic logic signed [SLACK_W-1:0] widen(input logic [TIME_WIDTH-1:0] v);
      widen = {2'b00, v};
   endfunction

   function automatic logic [TIME_WIDTH-1:0] clamp_slice(input logic signed [SLACK_W-1:0] v);
      if (v[SLACK_W-1]) begin
         clamp_slice = '0;
      end else if (v[SLACK_W-2:TIME_WIDTH] != '0) begin
         clamp_slice = '1;
      end else begin
         clamp_slice = v[TIME_WIDTH-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/least_slack_time_picker.sv =====
// least_slack_time_picker: top level, front queue feeding the batch evaluator
// depends on lstp_pkg, lstp_front and lstp_back
// a decide item is held in a queue slot, then popped into the result register behind rsp_valid
// throughput: one item per cycle unless a decide item waits on a held result, set by the update in lstp_back
// a two entry queue lets the input keep flowing while a result waits to be taken
// reset: synchronous, empties the queue and opens a batch at time zero
`timescale 1ns / 1ps
`default_nettype none

module least_slack_time_picker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lstp_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lstp_pkg::rsp_type      rsp_data
);

   lstp_pkg::head_type head;
   logic               pop;

   lstp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .head      (head),
      .pop       (pop)
   );

   lstp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_pop_needs_head: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("pop from empty queue");

   a_accept_reaches_head: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> head.valid)
      else $error("accepted item missing from queue");

   a_no_decide_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(pop && head.entry.op == lstp_pkg::OP_DECIDE && rsp_valid && rsp_stall))
      else $error("decide would overwrite held result");

   a_missed_zero_slice: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.missed) |-> (rsp_data.selected && rsp_data.slice == '0))
      else $error("missed result without selection or with nonzero slice");
`endif

endmodule

`default_nettype wire

// ===== rtl/lstp_front.sv =====
// lstp_front: accepts items, classifies the command and holds them in a two entry queue
// depends on lstp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lstp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire lstp_pkg::req_type req_data,
   output lstp_pkg::head_type     head,
   input  wire logic              pop
);

   lstp_pkg::entry_type slot_ff [2];
   logic [1:0]          count_ff;
   logic [1:0]          count_in;
   logic                wr_ptr_ff;
   logic                wr_ptr_in;
   logic                rd_ptr_ff;
   logic                rd_ptr_in;
   logic                push;
   lstp_pkg::op_type    op;

   // command decode
   always_comb begin
      op = lstp_pkg::op_type'(req_data.command);
   end

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= '{op: op, data: req_data};
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.entry = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

// ===== rtl/lstp_back.sv =====
// lstp_back: runs queued items against the batch state and registers the decision
// depends on lstp_pkg
`timescale 1ns / 1ps
`default_nettype none

module lstp_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lstp_pkg::head_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output lstp_pkg::rsp_type       rsp_data
);

   localparam int TW = lstp_pkg::TIME_WIDTH;
   localparam int IW = lstp_pkg::ID_WIDTH;
   localparam int SW = lstp_pkg::SLACK_W;
   localparam int LW = lstp_pkg::LIMIT_W;

   logic [TW-1:0]        batch_time_ff, batch_time_in;
   logic                 miss_found_ff, miss_found_in;
   logic [IW-1:0]        miss_id_ff, miss_id_in;
   logic                 best_found_ff, best_found_in;
   logic signed [SW-1:0] best_slack_ff, best_slack_in;
   logic [IW-1:0]        best_id_ff, best_id_in;
   logic signed [LW-1:0] best_limit_ff, best_limit_in;
   logic signed [SW-1:0] preempt_gap_ff, preempt_gap_in;
   logic                 release_phase_ff, release_phase_in;
   logic signed [SW-1:0] nearest_release_ff, nearest_release_in;
   logic                 order_fault_ff, order_fault_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   lstp_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   lstp_pkg::req_type    d;
   logic signed [SW-1:0] dl_s, rem_s, rel_s, bt_s;
   logic signed [SW-1:0] slack, to_dl, gap, rslack, lim_ext, chosen;
   logic                 out_free;

   assign d        = head.entry.data;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = head.valid && ((head.entry.op != lstp_pkg::OP_DECIDE) || out_free);

   always_comb begin
      dl_s    = lstp_pkg::widen(d.deadline);
      rem_s   = lstp_pkg::widen(d.remaining);
      rel_s   = lstp_pkg::widen(d.release_at);
      bt_s    = lstp_pkg::widen(batch_time_ff);
      slack   = dl_s - bt_s - rem_s;
      to_dl   = dl_s - bt_s;
      gap     = rel_s - bt_s;
      rslack  = dl_s - rel_s - rem_s;
      lim_ext = {best_limit_ff[LW-1], best_limit_ff};
      chosen  = (preempt_gap_ff < lim_ext) ? preempt_gap_ff : lim_ext;

      batch_time_in      = batch_time_ff;
      miss_found_in      = miss_found_ff;
      miss_id_in         = miss_id_ff;
      best_found_in      = best_found_ff;
      best_slack_in      = best_slack_ff;
      best_id_in         = best_id_ff;
      best_limit_in      = best_limit_ff;
      preempt_gap_in     = preempt_gap_ff;
      release_phase_in   = release_phase_ff;
      nearest_release_in = nearest_release_ff;
      order_fault_in     = order_fault_ff;
      rsp_valid_in       = rsp_valid_ff && rsp_stall;
      rsp_data_in        = rsp_data_ff;

      if (pop) begin
         unique case (head.entry.op)
            lstp_pkg::OP_BEGIN: begin
               batch_time_in      = d.now;
               miss_found_in      = 1'b0;
               miss_id_in         = '0;
               best_found_in      = 1'b0;
               best_slack_in      = '0;
               best_id_in         = '0;
               best_limit_in      = '0;
               preempt_gap_in     = lstp_pkg::GAP_NONE;
               release_phase_in   = 1'b0;
               nearest_release_in = lstp_pkg::IDLE_GAP;
               order_fault_in     = 1'b0;
            end
            lstp_pkg::OP_RUN: begin
               if (release_phase_ff) begin
                  order_fault_in = 1'b1;
               end else begin
                  if (d.deadline <= batch_time_ff &&
                      (!miss_found_ff || d.thread_id < miss_id_ff)) begin
                     miss_found_in = 1'b1;
                     miss_id_in    = d.thread_id;
                  end
                  if (!best_found_ff || slack < best_slack_ff ||
                      (slack == best_slack_ff && d.thread_id < best_id_ff)) begin
                     best_found_in = 1'b1;
                     best_slack_in = slack;
                     best_id_in    = d.thread_id;
                     best_limit_in = (rem_s > to_dl) ? to_dl[LW-1:0] : rem_s[LW-1:0];
                  end
               end
            end
            lstp_pkg::OP_RELEASE: begin
               release_phase_in = 1'b1;
               if (gap < nearest_release_ff) begin
                  nearest_release_in = gap;
               end
               if (best_found_ff && (rslack < best_slack_ff ||
                   (rslack == best_slack_ff && d.thread_id < best_id_ff)) &&
                   gap < preempt_gap_ff) begin
                  preempt_gap_in = gap;
               end
            end
            lstp_pkg::OP_DECIDE: begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.sequence_error = order_fault_ff;
               priority if (miss_found_ff) begin
                  rsp_data_in.selected  = 1'b1;
                  rsp_data_in.chosen_id = miss_id_ff;
                  rsp_data_in.slice     = '0;
                  rsp_data_in.missed    = 1'b1;
               end else if (best_found_ff) begin
                  rsp_data_in.selected  = 1'b1;
                  rsp_data_in.chosen_id = best_id_ff;
                  rsp_data_in.slice     = lstp_pkg::clamp_slice(chosen);
                  rsp_data_in.missed    = 1'b0;
               end else begin
                  rsp_data_in.selected  = 1'b0;
                  rsp_data_in.chosen_id = '0;
                  rsp_data_in.slice     = lstp_pkg::clamp_slice(nearest_release_ff);
                  rsp_data_in.missed    = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_time_ff      <= '0;
         miss_found_ff      <= 1'b0;
         miss_id_ff         <= '0;
         best_found_ff      <= 1'b0;
         best_slack_ff      <= '0;
         best_id_ff         <= '0;
         best_limit_ff      <= '0;
         preempt_gap_ff     <= lstp_pkg::GAP_NONE;
         release_phase_ff   <= 1'b0;
         nearest_release_ff <= lstp_pkg::IDLE_GAP;
         order_fault_ff     <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         batch_time_ff      <= batch_time_in;
         miss_found_ff      <= miss_found_in;
         miss_id_ff         <= miss_id_in;
         best_found_ff      <= best_found_in;
         best_slack_ff      <= best_slack_in;
         best_id_ff         <= best_id_in;
         best_limit_ff      <= best_limit_in;
         preempt_gap_ff     <= preempt_gap_in;
         release_phase_ff   <= release_phase_in;
         nearest_release_ff <= nearest_release_in;
         order_fault_ff     <= order_fault_in;
         rsp_valid_ff       <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire
